>>> rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the melody step sequencer
// Holds the transaction structs, the step table geometry and the mode and
// phase codes.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int MAX_STEPS = 64;
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 7;
  localparam int FREQ_W    = 16;
  localparam int DUR_W     = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STEPS);

  // input modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_PLAY = 2'd2;
  localparam logic [1:0] MODE_STOP = 2'd3;

  // sequencer phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_PLAYING = 2'd2;
  localparam logic [1:0] PH_ADVANCE = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  entry_index;
    logic [FREQ_W-1:0] entry_freq_hz;
    logic [DUR_W-1:0]  entry_duration_ms;
    logic [LEN_W-1:0]  melody_length;
    logic              loop_enable;
  } mss_in_t;

  typedef struct packed {
    logic              tone_enable;
    logic [FREQ_W-1:0] tone_freq_hz;
    logic              playing;
    logic [IDX_W-1:0]  current_step;
    logic [1:0]        sequencer_phase;
  } mss_out_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  duration;
  } mss_entry_t;

endpackage

>>> rtl/mss_step_mem.sv
// ----------------------------------------------------------------------------
// mss_step_mem: step table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mss_step_mem
  import mss_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  mss_entry_t       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output mss_entry_t       rd_data
);

  mss_entry_t mem [MAX_STEPS];
  mss_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/melody_step_sequencer_unit.sv
// ----------------------------------------------------------------------------
// melody_step_sequencer_unit: buzzer melody step sequencer
// Walks a loaded step table on millisecond ticks and drives tone outputs.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     start / busy              in_item  (mss_in_t)
//  result    out_valid (one cycle)     out_result (mss_out_t)
//
//  a tick in the start step phase stalls the input: it issues the registered
//  step table read, and busy is high in the cycle after, while the data returns
//  every other transaction is taken without a stall; its result strobes the cycle after
//  reset puts the sequencer idle with the tone off; the table is not cleared
//  results cannot be stalled: out_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
module melody_step_sequencer_unit
  import mss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mss_in_t  in_item,
  output logic     out_valid,
  output mss_out_t out_result
);

  logic [IDX_W-1:0]  step_r,  step_nxt;
  logic [LEN_W-1:0]  len_r,   len_nxt;
  logic              loop_r,  loop_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [DUR_W-1:0]  ms_r,    ms_nxt;
  logic              tone_r,  tone_nxt;
  logic [FREQ_W-1:0] freq_r,  freq_nxt;
  logic              pend_r,  pend_nxt;
  logic              valid_r, valid_nxt;

  logic              accept;
  logic              rd_issue;
  logic              wr_en;
  mss_entry_t        wr_data;
  mss_entry_t        rd_data;
  logic [LEN_W-1:0]  step_inc;
  logic [DUR_W-1:0]  ms_dec;

  assign busy     = pend_r;
  assign accept   = start && !pend_r;
  assign rd_issue = accept && (in_item.mode == MODE_TICK) && (phase_r == PH_START);
  assign wr_en    = accept && (in_item.mode == MODE_LOAD);
  assign wr_data  = '{freq: in_item.entry_freq_hz, duration: in_item.entry_duration_ms};

  mss_step_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_item.entry_index),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (step_r),
    .rd_data (rd_data)
  );

  assign step_inc = {1'b0, step_r} + LEN_W'(1);
  assign ms_dec   = (ms_r != '0) ? ms_r - DUR_W'(1) : ms_r;

  always_comb begin
    step_nxt  = step_r;
    len_nxt   = len_r;
    loop_nxt  = loop_r;
    phase_nxt = phase_r;
    ms_nxt    = ms_r;
    tone_nxt  = tone_r;
    freq_nxt  = freq_r;
    pend_nxt  = 1'b0;
    valid_nxt = 1'b0;

    if (pend_r) begin
      // table data for the start step is back
      tone_nxt  = (rd_data.freq != '0);
      freq_nxt  = rd_data.freq;
      ms_nxt    = rd_data.duration;
      phase_nxt = PH_PLAYING;
      valid_nxt = 1'b1;
    end else if (accept) begin
      unique case (in_item.mode)
        MODE_TICK: begin
          unique case (phase_r)
            PH_START: begin
              pend_nxt = 1'b1;
            end
            PH_PLAYING: begin
              ms_nxt = ms_dec;
              if (ms_dec == '0) begin
                phase_nxt = PH_ADVANCE;
              end
              valid_nxt = 1'b1;
            end
            PH_ADVANCE: begin
              if (step_inc >= len_r) begin
                if (loop_r) begin
                  step_nxt  = '0;
                  phase_nxt = PH_START;
                end else begin
                  tone_nxt  = 1'b0;
                  freq_nxt  = '0;
                  len_nxt   = '0;
                  loop_nxt  = 1'b0;
                  step_nxt  = '0;
                  phase_nxt = PH_IDLE;
                  ms_nxt    = '0;
                end
              end else begin
                step_nxt  = step_inc[IDX_W-1:0];
                phase_nxt = PH_START;
              end
              valid_nxt = 1'b1;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
        MODE_LOAD: begin
          valid_nxt = 1'b1;
        end
        MODE_PLAY: begin
          tone_nxt  = 1'b0;
          freq_nxt  = '0;
          len_nxt   = '0;
          loop_nxt  = 1'b0;
          step_nxt  = '0;
          phase_nxt = PH_IDLE;
          ms_nxt    = '0;
          if (in_item.melody_length != '0) begin
            len_nxt   = (in_item.melody_length > MAX_LEN) ? MAX_LEN : in_item.melody_length;
            loop_nxt  = in_item.loop_enable;
            phase_nxt = PH_START;
          end
          valid_nxt = 1'b1;
        end
        default: begin
          tone_nxt  = 1'b0;
          freq_nxt  = '0;
          len_nxt   = '0;
          loop_nxt  = 1'b0;
          step_nxt  = '0;
          phase_nxt = PH_IDLE;
          ms_nxt    = '0;
          valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      len_r   <= '0;
      loop_r  <= 1'b0;
      phase_r <= PH_IDLE;
      ms_r    <= '0;
      tone_r  <= 1'b0;
      freq_r  <= '0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      len_r   <= len_nxt;
      loop_r  <= loop_nxt;
      phase_r <= phase_nxt;
      ms_r    <= ms_nxt;
      tone_r  <= tone_nxt;
      freq_r  <= freq_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid                  = valid_r;
  assign out_result.tone_enable     = tone_r;
  assign out_result.tone_freq_hz    = freq_r;
  assign out_result.playing         = (phase_r != PH_IDLE);
  assign out_result.current_step    = step_r;
  assign out_result.sequencer_phase = phase_r;

  // the table read stall clears in the next cycle, which always brings a result
  a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> (!pend_r && out_valid))
    else $error("table read stall did not finish in one cycle");

  // a transaction that needs no table read reports on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !rd_issue) |=> out_valid)
    else $error("result missing after transaction");

  // a read completes into the playing phase
  a_read_to_play: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> (phase_r == PH_PLAYING))
    else $error("start step did not enter playing");

  // the tone is silent with zero frequency whenever idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (!tone_r && freq_r == '0 && step_r == '0 && len_r == '0))
    else $error("idle sequencer not silent");

  // the step index never reaches the active length while a melody runs
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> ({1'b0, step_r} < len_r))
    else $error("step index beyond melody length");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the melody step sequencer
// Drives tick, load, play and stop transactions through the start/busy port
// with random gaps, predicts every result strobe in a scoreboard class and
// compares the result fields in order.
// ----------------------------------------------------------------------------
module tb
  import mss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS    = 1650;
  localparam int IDLE_LIMIT = 2000;

  class melody_scoreboard;
    logic [FREQ_W-1:0] freq_tbl [MAX_STEPS];
    logic [DUR_W-1:0]  dur_tbl  [MAX_STEPS];
    logic [LEN_W-1:0]  step_cnt;
    logic [LEN_W-1:0]  seq_len;
    logic              loop_on;
    logic              tone_on;
    logic [FREQ_W-1:0] tone_hz;
    logic [DUR_W-1:0]  ms_left;
    logic [1:0]        phase;
    mss_out_t          expected_outs[$];
    int unsigned       mode_cnt [4];
    int unsigned       checked;
    int unsigned       mismatches;
    int unsigned       wraps;
    int unsigned       melody_ends;

    function new();
      halt();
    endfunction

    function void halt();
      tone_on  = 1'b0;
      tone_hz  = '0;
      seq_len  = '0;
      loop_on  = 1'b0;
      step_cnt = '0;
      phase    = PH_IDLE;
      ms_left  = '0;
    endfunction

    function void apply_tick();
      logic [IDX_W-1:0] idx;
      idx = step_cnt[IDX_W-1:0];
      case (phase)
        PH_START: begin
          tone_on = (freq_tbl[idx] != 0);
          tone_hz = freq_tbl[idx];
          ms_left = dur_tbl[idx];
          phase   = PH_PLAYING;
        end
        PH_PLAYING: begin
          if (ms_left != 0) ms_left = ms_left - 1'b1;
          if (ms_left == 0) phase = PH_ADVANCE;
        end
        PH_ADVANCE: begin
          step_cnt = step_cnt + 1'b1;
          if (step_cnt >= seq_len) begin
            if (loop_on) begin
              step_cnt = '0;
              phase    = PH_START;
              wraps++;
            end else begin
              halt();
              melody_ends++;
            end
          end else begin
            phase = PH_START;
          end
        end
        default: ;
      endcase
    endfunction

    function void record_item(mss_in_t it);
      mss_out_t r;
      mode_cnt[it.mode]++;
      case (it.mode)
        MODE_TICK: apply_tick();
        MODE_LOAD: begin
          freq_tbl[it.entry_index] = it.entry_freq_hz;
          dur_tbl[it.entry_index]  = it.entry_duration_ms;
        end
        MODE_PLAY: begin
          // a running melody is dropped first, zero length just stops
          halt();
          if (it.melody_length != 0) begin
            seq_len  = (it.melody_length > MAX_LEN) ? MAX_LEN : it.melody_length;
            loop_on  = it.loop_enable;
            step_cnt = '0;
            phase    = PH_START;
          end
        end
        default: halt();
      endcase
      r.tone_enable     = tone_on;
      r.tone_freq_hz    = tone_hz;
      r.playing         = (phase != PH_IDLE);
      r.current_step    = step_cnt[IDX_W-1:0];
      r.sequencer_phase = phase;
      expected_outs.push_back(r);
    endfunction

    function void check_result(mss_out_t got);
      mss_out_t want;
      checked++;
      if (expected_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: tone %b/%0d play %b step %0d phase %0d",
                   $time, got.tone_enable, got.tone_freq_hz, got.playing,
                   got.current_step, got.sequencer_phase);
        return;
      end
      want = expected_outs.pop_front();
      if (got.tone_enable !== want.tone_enable || got.tone_freq_hz !== want.tone_freq_hz ||
          got.playing !== want.playing || got.current_step !== want.current_step ||
          got.sequencer_phase !== want.sequencer_phase) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp tone %b/%0d play %b step %0d phase %0d",
                   $time, want.tone_enable, want.tone_freq_hz, want.playing,
                   want.current_step, want.sequencer_phase);
          $display("    got tone %b/%0d play %b step %0d phase %0d",
                   got.tone_enable, got.tone_freq_hz, got.playing,
                   got.current_step, got.sequencer_phase);
        end
      end
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  mss_in_t  in_item = '0;
  logic     out_valid;
  mss_out_t out_result;

  melody_scoreboard sb = new();
  bit               loaded [MAX_STEPS];
  bit               no_gaps = 1'b0;
  int unsigned      sent = 0;
  int unsigned      idle_cycles = 0;

  melody_step_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // results are checked before the new transaction is noted, both in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_result);
      if (start && !busy) sb.record_item(in_item);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic mss_in_t rand_item();
    mss_in_t it;
    it.mode              = 2'($urandom);
    it.entry_index       = IDX_W'($urandom);
    it.entry_freq_hz     = FREQ_W'($urandom);
    it.entry_duration_ms = DUR_W'($urandom);
    it.melody_length     = LEN_W'($urandom);
    it.loop_enable       = 1'($urandom);
    return it;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < MAX_STEPS && loaded[n]) n++;
    return n;
  endfunction

  // melody length that only reaches loaded steps; past the table only when full
  function automatic logic [LEN_W-1:0] pick_len();
    int p;
    p = loaded_prefix();
    if (p == 0) return '0;
    if (p == MAX_STEPS && $urandom_range(0, 4) == 0)
      return LEN_W'($urandom_range(MAX_STEPS, (1 << LEN_W) - 1));
    if ($urandom_range(0, 9) < 7) return LEN_W'($urandom_range(1, (p < 6) ? p : 6));
    return LEN_W'($urandom_range(1, p));
  endfunction

  function automatic logic [FREQ_W-1:0] rand_freq();
    if ($urandom_range(0, 3) == 0) return '0;
    return FREQ_W'($urandom_range(1, (1 << FREQ_W) - 1));
  endfunction

  // mostly short steps, now and then a long one that gets interrupted
  function automatic logic [DUR_W-1:0] rand_dur();
    if ($urandom_range(0, 19) == 0) return DUR_W'($urandom);
    return DUR_W'($urandom_range(0, 4));
  endfunction

  task automatic send_item(input mss_in_t it);
    int r;
    int gap;
    if (it.mode == MODE_LOAD) loaded[it.entry_index] = 1'b1;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start   <= 1'b0;
      in_item <= rand_item();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic do_cmd(input logic [1:0] mode);
    mss_in_t it;
    it = rand_item();
    it.mode = mode;
    send_item(it);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] freq,
                            input logic [DUR_W-1:0] dur);
    mss_in_t it;
    it = rand_item();
    it.mode              = MODE_LOAD;
    it.entry_index       = idx;
    it.entry_freq_hz     = freq;
    it.entry_duration_ms = dur;
    send_item(it);
  endtask

  task automatic play_melody(input logic [LEN_W-1:0] len, input logic loop_en);
    mss_in_t it;
    it = rand_item();
    it.mode          = MODE_PLAY;
    it.melody_length = len;
    it.loop_enable   = loop_en;
    send_item(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    mss_in_t it;
    int      sel;
    int      n;
    int      p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle commands, zero length, extremes, rest, wrap, restart
    do_cmd(MODE_STOP);
    do_cmd(MODE_TICK);
    play_melody('0, 1'b1);
    load_entry('0, '1, 16'd2);
    load_entry(6'd1, '0, '0);
    load_entry('1, 16'd1, '1);
    play_melody(7'd2, 1'b0);
    repeat (7) do_cmd(MODE_TICK);
    play_melody(7'd2, 1'b1);
    repeat (7) do_cmd(MODE_TICK);
    play_melody(7'd1, 1'b0);
    do_cmd(MODE_TICK);
    do_cmd(MODE_STOP);
    drain_results();

    while (sent < N_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // well-formed melody: grow the table, play it, run it on ticks
        n = $urandom_range(1, 3);
        repeat (n) begin
          p = loaded_prefix();
          if (p < MAX_STEPS && $urandom_range(0, 9) < 6)
            load_entry(IDX_W'(p), rand_freq(), rand_dur());
          else
            load_entry(IDX_W'($urandom), rand_freq(), rand_dur());
        end
        play_melody(pick_len(), 1'($urandom));
        n = $urandom_range(2, 60);
        repeat (n) begin
          sel = $urandom_range(0, 99);
          if (sel < 2) do_cmd(MODE_STOP);
          else if (sel < 4) play_melody(pick_len(), 1'($urandom));
          else if (sel < 7) load_entry(IDX_W'($urandom), rand_freq(), rand_dur());
          else do_cmd(MODE_TICK);
        end
      end else if (sel < 95) begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          it = rand_item();
          it.entry_duration_ms = rand_dur();
          if (it.mode == MODE_PLAY)
            it.melody_length = ($urandom_range(0, 4) == 0) ? '0 : pick_len();
          send_item(it);
        end
      end else begin
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d transactions: %0d ticks, %0d loads, %0d plays, %0d stops",
             sent, sb.mode_cnt[MODE_TICK], sb.mode_cnt[MODE_LOAD],
             sb.mode_cnt[MODE_PLAY], sb.mode_cnt[MODE_STOP]);
    $display("%0d results checked, %0d melodies ran out, %0d loop wraps, %0d mismatches",
             sb.checked, sb.melody_ends, sb.wraps, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mss_pkg.sv
rtl/mss_step_mem.sv
rtl/melody_step_sequencer_unit.sv
verif/tb.sv
